// ===== hw/rtl/crc_checked_frame_decoder_macros.svh =====
// Assertion macros for the CRC-checked frame decoder checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef CRC_CHECKED_FRAME_DECODER_MACROS_SVH
`define CRC_CHECKED_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CFD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/cfd_pkg.sv =====
// Shared types, codes and the bytewise CRC-32 function of the frame decoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package cfd_pkg;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
	// header (14) plus trailing CRC (4)
	localparam logic [31:0] FRAME_OVERHEAD = 32'd18;
	localparam logic [24:0] VERSION_END_BYTES = 25'd5;
	localparam logic [24:0] TYPE_END_BYTES = 25'd6;
	localparam logic [24:0] LENGTH_END_BYTES = 25'd10;
	localparam logic [1:0] LAST_SECTION_IDX = 2'd3;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef enum logic [2:0] {
		PH_MAGIC,
		PH_VERSION,
		PH_TYPE,
		PH_LENGTH,
		PH_RESERVED,
		PH_PAYLOAD,
		PH_CRC
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER,
		KIND_PAYLOAD,
		KIND_END
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_BAD_MAGIC,
		ST_BAD_VERSION,
		ST_BAD_TYPE,
		ST_OVERSIZED,
		ST_CRC_MISMATCH
	} status_t;

	typedef enum logic [2:0] {
		REG_MAGIC_WORD,
		REG_EXPECTED_VERSION,
		REG_TYPE_MIN,
		REG_TYPE_MAX,
		REG_MAX_PAYLOAD
	} reg_index_t;

	typedef struct packed {
		logic [31:0] magic_word;
		logic [7:0]  expected_version;
		logic [7:0]  type_min;
		logic [7:0]  type_max;
		logic [23:0] max_payload;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [7:0]  msg_type;
		logic [7:0]  version;
		status_t     status;
		logic [24:0] frame_bytes;
	} res_t;

	// Reflected CRC-32, one byte: eight shift/xor steps on a 32-bit word.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/cfd_front.sv =====
// Front end: frame parser, header checks and running CRC, one byte per transaction.
// Produces at most one result item per byte. Depends on cfd_pkg.
`timescale 1ns / 1ps

module cfd_front #(
	parameter int LENGTH_BITS = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  logic [7:0]      in_byte,
	input  cfd_pkg::cfg_t   cfg,
	output logic            push,
	output cfd_pkg::res_t   item
);
	import cfd_pkg::*;

	phase_t                   phase_q, phase_d;
	logic [1:0]               idx_q;
	logic [LENGTH_BITS-1:0]   len_q;
	logic                     high_q;
	logic [LENGTH_BITS-1:0]   rem_q;
	logic [31:0]              crc_q;
	logic [31:0]              crcrx_q;
	logic [7:0]               type_q;
	logic [7:0]               ver_q;

	logic [31:0]              crc_nx;
	logic [7:0]               magic_byte;
	logic [31:0]              part;
	logic [LENGTH_BITS-1:0]   len_nx;
	logic                     high_nx;
	logic                     oversize;
	logic [31:0]              crcrx_nx;
	logic                     type_ok;
	logic                     finish;

	assign crc_nx     = crc_byte(crc_q, in_byte);
	assign magic_byte = cfg.magic_word[{idx_q, 3'b000} +: 8];
	assign part       = {24'd0, in_byte} << {idx_q, 3'b000};
	assign len_nx     = len_q | part[LENGTH_BITS-1:0];
	// any set bit at or above LENGTH_BITS makes the frame oversized
	assign high_nx    = high_q | ((part >> LENGTH_BITS) != 32'd0);
	assign oversize   = high_nx || (32'(len_nx) > {8'd0, cfg.max_payload});
	assign crcrx_nx   = crcrx_q | part;
	assign type_ok    = (in_byte >= cfg.type_min) && (in_byte <= cfg.type_max);

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_MAGIC: begin
				if (in_byte == magic_byte && idx_q == LAST_SECTION_IDX)
					phase_d = PH_VERSION;
			end
			PH_VERSION: begin
				phase_d = (in_byte == cfg.expected_version) ? PH_TYPE : PH_MAGIC;
			end
			PH_TYPE: begin
				phase_d = type_ok ? PH_LENGTH : PH_MAGIC;
			end
			PH_LENGTH: begin
				if (idx_q == LAST_SECTION_IDX)
					phase_d = oversize ? PH_MAGIC : PH_RESERVED;
			end
			PH_RESERVED: begin
				if (idx_q == LAST_SECTION_IDX)
					phase_d = (len_q == '0) ? PH_CRC : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				if (rem_q == LENGTH_BITS'(1))
					phase_d = PH_CRC;
			end
			PH_CRC: begin
				if (idx_q == LAST_SECTION_IDX)
					phase_d = PH_MAGIC;
			end
			default: phase_d = PH_MAGIC;
		endcase
	end

	// result item
	always_comb begin
		push             = 1'b0;
		item.kind        = KIND_HEADER;
		item.data        = 8'd0;
		item.msg_type    = type_q;
		item.version     = ver_q;
		item.status      = ST_OK;
		item.frame_bytes = 25'd0;
		case (phase_q)
			PH_MAGIC: begin
				if (in_byte != magic_byte) begin
					push             = 1'b1;
					item.kind        = KIND_END;
					item.status      = ST_BAD_MAGIC;
					item.frame_bytes = 25'(idx_q) + 25'd1;
				end
			end
			PH_VERSION: begin
				item.version = in_byte;
				if (in_byte != cfg.expected_version) begin
					push             = 1'b1;
					item.kind        = KIND_END;
					item.status      = ST_BAD_VERSION;
					item.frame_bytes = VERSION_END_BYTES;
				end
			end
			PH_TYPE: begin
				item.msg_type = in_byte;
				if (!type_ok) begin
					push             = 1'b1;
					item.kind        = KIND_END;
					item.status      = ST_BAD_TYPE;
					item.frame_bytes = TYPE_END_BYTES;
				end
			end
			PH_LENGTH: begin
				if (idx_q == LAST_SECTION_IDX && oversize) begin
					push             = 1'b1;
					item.kind        = KIND_END;
					item.status      = ST_OVERSIZED;
					item.frame_bytes = LENGTH_END_BYTES;
				end
			end
			PH_RESERVED: begin
				push = (idx_q == LAST_SECTION_IDX);
			end
			PH_PAYLOAD: begin
				push      = 1'b1;
				item.kind = KIND_PAYLOAD;
				item.data = in_byte;
			end
			PH_CRC: begin
				if (idx_q == LAST_SECTION_IDX) begin
					push             = 1'b1;
					item.kind        = KIND_END;
					item.status      = (crcrx_nx == ~crc_q) ? ST_OK : ST_CRC_MISMATCH;
					item.frame_bytes = 25'(32'(len_q) + FRAME_OVERHEAD);
				end
			end
			default: push = 1'b0;
		endcase
		push = push & take;
	end

	assign finish = push && (item.kind == KIND_END);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC;
			idx_q   <= 2'd0;
			len_q   <= '0;
			high_q  <= 1'b0;
			rem_q   <= '0;
			crc_q   <= CRC_INIT;
			crcrx_q <= 32'd0;
			type_q  <= 8'd0;
			ver_q   <= 8'd0;
		end else if (take) begin
			if (finish) begin
				phase_q <= PH_MAGIC;
				idx_q   <= 2'd0;
				len_q   <= '0;
				high_q  <= 1'b0;
				rem_q   <= '0;
				crc_q   <= CRC_INIT;
				crcrx_q <= 32'd0;
				type_q  <= 8'd0;
				ver_q   <= 8'd0;
			end else begin
				phase_q <= phase_d;
				idx_q   <= (phase_d != phase_q) ? 2'd0 : idx_q + 2'd1;
				if (phase_q != PH_CRC)
					crc_q <= crc_nx;
				case (phase_q)
					PH_VERSION:  ver_q   <= in_byte;
					PH_TYPE:     type_q  <= in_byte;
					PH_LENGTH: begin
						len_q  <= len_nx;
						high_q <= high_nx;
					end
					PH_RESERVED: rem_q   <= len_q;
					PH_PAYLOAD:  rem_q   <= rem_q - LENGTH_BITS'(1);
					PH_CRC:      crcrx_q <= crcrx_nx;
					default:     ;
				endcase
			end
		end
	end

endmodule

// ===== hw/rtl/cfd_queue.sv =====
// Short result queue between parser and output stage.
// Register-based FIFO of result items. Depends on cfd_pkg.
`timescale 1ns / 1ps

module cfd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cfd_pkg::res_t   push_item,
	input  logic            pop,
	output cfd_pkg::res_t   head,
	output logic            empty,
	output logic            full
);
	import cfd_pkg::*;

	res_t               slot_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_q;
	logic [QPTR_W-1:0]  rd_q;
	logic [QPTR_W:0]    cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QPTR_W'(1);
			if (pop)
				rd_q <= rd_q + QPTR_W'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (QPTR_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QPTR_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/cfd_back.sv =====
// Back end: output register that drains the result queue onto the master stream.
// Packs result items into tdata/tuser/tlast. Depends on cfd_pkg.
`timescale 1ns / 1ps

module cfd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  cfd_pkg::res_t   head,
	input  logic            empty,
	output logic            pop,
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output logic [55:0]     m_axis_tdata,
	output logic [1:0]      m_axis_tuser,
	output logic            m_axis_tlast
);
	import cfd_pkg::*;

	logic  out_valid_q;
	res_t  out_q;

	assign pop = !empty && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (!out_valid_q || m_axis_tready)
			out_valid_q <= !empty;
	end

	always_ff @(posedge clk) begin
		if (pop)
			out_q <= head;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_q.frame_bytes, out_q.status, out_q.version,
		out_q.msg_type, out_q.data};
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tlast  = (out_q.kind == KIND_END);

endmodule

// ===== hw/rtl/crc_checked_frame_decoder.sv =====
// Top level of the CRC-32 checked frame decoder: config registers, parser,
// result queue and output stage. Depends on cfd_pkg, cfd_front, cfd_queue, cfd_back.
// Throughput: one byte per cycle while the result queue is not full; the CRC update is combinational.
// Each result is registered in a queue slot and then in the output register before the master stream.
// Reset (arst_n low, asynchronous) returns the parser to magic search, empties the
// queue and loads the register defaults; no clearing pass is needed.
`timescale 1ns / 1ps

module crc_checked_frame_decoder #(
	parameter int LENGTH_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] out_byte, [15:8] msg_type, [23:16] version, [26:24] status,
	// [51:27] frame_bytes, [55:52] zero
	output logic [55:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,   // [1:0] out_kind
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import cfd_pkg::*;

	cfg_t  cfg_q;
	logic  take;
	logic  push;
	res_t  push_item;
	res_t  head;
	logic  empty;
	logic  full;
	logic  pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic_word       <= 32'd0;
			cfg_q.expected_version <= 8'd1;
			cfg_q.type_min         <= 8'd0;
			cfg_q.type_max         <= 8'd255;
			cfg_q.max_payload      <= 24'd65536;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_MAGIC_WORD:       cfg_q.magic_word       <= cfg_data;
				REG_EXPECTED_VERSION: cfg_q.expected_version <= cfg_data[7:0];
				REG_TYPE_MIN:         cfg_q.type_min         <= cfg_data[7:0];
				REG_TYPE_MAX:         cfg_q.type_max         <= cfg_data[7:0];
				REG_MAX_PAYLOAD:      cfg_q.max_payload      <= cfg_data[23:0];
				default:              ;
			endcase
		end
	end

	assign s_axis_tready = !full;
	assign take          = s_axis_tvalid && s_axis_tready;

	cfd_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.in_byte (s_axis_tdata),
		.cfg     (cfg_q),
		.push    (push),
		.item    (push_item)
	);

	cfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	cfd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.empty         (empty),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ===== hw/rtl/cfd_checker.sv =====
// Port-level checker for the frame decoder, bound to the top level.
// Depends on cfd_pkg and crc_checked_frame_decoder_macros.svh.
`timescale 1ns / 1ps
`include "crc_checked_frame_decoder_macros.svh"

module cfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast
);
	import cfd_pkg::*;

	`CFD_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid,
		"result dropped while stalled")
	`CFD_ASSERT_IMP(a_last_kind, m_axis_tvalid, m_axis_tlast == (m_axis_tuser == KIND_END),
		"tlast does not match end kind")
	`CFD_ASSERT_IMP(a_byte_zero, m_axis_tvalid && m_axis_tuser != KIND_PAYLOAD,
		m_axis_tdata[7:0] == 8'd0, "data byte set outside payload")
	`CFD_ASSERT_IMP(a_status_zero, m_axis_tvalid && !m_axis_tlast,
		m_axis_tdata[55:24] == 32'd0, "status or length set on non-end transaction")

endmodule

bind crc_checked_frame_decoder cfd_checker u_cfd_checker (.*);

// ===== tb/sv/testbench.sv =====
// Self-checking bench for crc_checked_frame_decoder: builds frames (good, bad CRC,
// bad header fields, broken magic, noise) and checks every decoder output against
// an in-bench frame parser. Depends on cfd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module testbench;
	import cfd_pkg::*;

	localparam int LEN_BITS = 24;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_SLACK = 4;
	localparam int HOLD_CYCLES = 80;

	typedef enum int {
		RX_ALWAYS,
		RX_RANDOM,
		RX_PERIODIC
	} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = 3'd0;
	logic [31:0] cfg_data = 32'd0;

	// register shadows, reset values
	logic [31:0] cfg_magic = 32'd0;
	logic [7:0]  cfg_ver = 8'd1;
	logic [7:0]  cfg_tmin = 8'd0;
	logic [7:0]  cfg_tmax = 8'd255;
	logic [23:0] cfg_max = 24'd65536;

	// parser model state
	phase_t        phase = PH_MAGIC;
	logic [23:0]   pos = 24'd0;
	logic [LEN_BITS-1:0] plen = '0;
	logic          len_high = 1'b0;
	logic [31:0]   crc_acc = 32'hFFFFFFFF;
	logic [31:0]   crc_rx = 32'd0;
	logic [7:0]    seen_type = 8'd0;
	logic [7:0]    seen_ver = 8'd0;

	res_t        decoded_q[$];
	logic [7:0]  frame_buf[$];

	int unsigned fail_count = 0;
	int unsigned bytes_sent = 0;
	int unsigned idle_cycles = 0;
	int          tx_max_gap = 0;
	int          tx_max_burst = 8;
	int          burst_left = 0;
	rx_mode_t    rx_mode = RX_ALWAYS;
	bit          hold_req = 1'b0;
	int          hold_left = 0;
	int unsigned rx_tick = 0;

	crc_checked_frame_decoder #(
		.LENGTH_BITS(LEN_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// reflected CRC-32, one data bit at a time, LSB first
	function automatic logic [31:0] crc32_update(input logic [31:0] acc, input logic [7:0] d);
		logic [31:0] c;
		c = acc;
		for (int k = 0; k < 8; k++) begin
			if (c[0] ^ d[k])
				c = (c >> 1) ^ 32'hEDB88320;
			else
				c = c >> 1;
		end
		return c;
	endfunction

	task automatic restart_parser();
		phase = PH_MAGIC;
		pos = '0;
		plen = '0;
		len_high = 1'b0;
		crc_acc = 32'hFFFFFFFF;
		crc_rx = 32'd0;
		seen_type = 8'd0;
		seen_ver = 8'd0;
	endtask

	task automatic push_decoded(input kind_t k, input logic [7:0] d, input status_t st,
			input logic [24:0] fb);
		res_t r;
		r.kind = k;
		r.data = d;
		r.msg_type = seen_type;
		r.version = seen_ver;
		r.status = st;
		r.frame_bytes = fb;
		decoded_q.insert(decoded_q.size(), r);
	endtask

	task automatic close_frame(input status_t st, input logic [24:0] fb);
		push_decoded(KIND_END, 8'd0, st, fb);
		restart_parser();
	endtask

	// advance the parser model by one accepted byte
	task automatic parse_byte(input logic [7:0] b);
		logic [63:0] part;
		logic [23:0] nxt;
		if (phase != PH_CRC)
			crc_acc = crc32_update(crc_acc, b);
		case (phase)
			PH_MAGIC: begin
				if (b != cfg_magic[8 * pos[1:0] +: 8])
					close_frame(ST_BAD_MAGIC, 25'(pos) + 25'd1);
				else if (pos >= 24'd3) begin
					phase = PH_VERSION;
					pos = '0;
				end else
					pos = pos + 24'd1;
			end
			PH_VERSION: begin
				seen_ver = b;
				if (b != cfg_ver)
					close_frame(ST_BAD_VERSION, 25'd5);
				else
					phase = PH_TYPE;
			end
			PH_TYPE: begin
				seen_type = b;
				if (b < cfg_tmin || b > cfg_tmax)
					close_frame(ST_BAD_TYPE, 25'd6);
				else begin
					phase = PH_LENGTH;
					pos = '0;
				end
			end
			PH_LENGTH: begin
				part = 64'(b) << (8 * pos[1:0]);
				if ((part >> LEN_BITS) != 64'd0)
					len_high = 1'b1;
				plen = plen | part[LEN_BITS-1:0];
				if (pos < 24'd3)
					pos = pos + 24'd1;
				else if (len_high || plen > cfg_max)
					close_frame(ST_OVERSIZED, 25'd10);
				else begin
					phase = PH_RESERVED;
					pos = '0;
				end
			end
			PH_RESERVED: begin
				if (pos < 24'd3)
					pos = pos + 24'd1;
				else begin
					pos = '0;
					phase = (plen == '0) ? PH_CRC : PH_PAYLOAD;
					push_decoded(KIND_HEADER, 8'd0, ST_OK, 25'd0);
				end
			end
			PH_PAYLOAD: begin
				nxt = pos + 24'd1;
				if (nxt >= plen) begin
					phase = PH_CRC;
					pos = '0;
				end else
					pos = nxt;
				push_decoded(KIND_PAYLOAD, b, ST_OK, 25'd0);
			end
			default: begin
				crc_rx = crc_rx | (32'(b) << (8 * pos[1:0]));
				if (pos < 24'd3)
					pos = pos + 24'd1;
				else
					close_frame((crc_rx == ~crc_acc) ? ST_OK : ST_CRC_MISMATCH,
						25'd18 + 25'(plen));
			end
		endcase
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_result();
		res_t want;
		if (decoded_q.size() == 0) begin
			$display("%0t: unexpected transaction: expected none, actual tuser %0d tdata %h",
				$time, m_axis_tuser, m_axis_tdata);
			fail_count++;
			return;
		end
		want = decoded_q.pop_front();
		compare_field("out_kind", 32'(want.kind), 32'(m_axis_tuser));
		compare_field("out_byte", 32'(want.data), 32'(m_axis_tdata[7:0]));
		compare_field("msg_type", 32'(want.msg_type), 32'(m_axis_tdata[15:8]));
		compare_field("version", 32'(want.version), 32'(m_axis_tdata[23:16]));
		compare_field("status", 32'(want.status), 32'(m_axis_tdata[26:24]));
		compare_field("frame_bytes", 32'(want.frame_bytes), 32'(m_axis_tdata[51:27]));
		compare_field("pad", 32'd0, 32'(m_axis_tdata[55:52]));
		compare_field("last", 32'(want.kind == KIND_END), 32'(m_axis_tlast));
	endtask

	// monitor and watchdog; values read here are the ones the DUT sampled
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				check_result();
			if (s_axis_tvalid && s_axis_tready)
				parse_byte(s_axis_tdata);
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, idle_cycles);
				$display("[crc_checked_frame_decoder] ERROR");
				$finish;
			end
		end
	end

	// output side: stall pattern plus an optional long hold-off
	always @(negedge clk) begin
		rx_tick++;
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_ALWAYS: m_axis_tready <= 1'b1;
				RX_RANDOM: m_axis_tready <= ($urandom_range(0, 2) != 0);
				default: m_axis_tready <= ((rx_tick % 8) >= 3);
			endcase
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, tx_max_burst);
			if (tx_max_gap > 0) begin
				gap = $urandom_range(1, tx_max_gap);
				@(negedge clk) s_axis_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic send_prefix(input int count);
		for (int i = 0; i < count && i < frame_buf.size(); i++)
			send_byte(frame_buf[i]);
	endtask

	// magic, version, type, LE length, 4 reserved, payload, LE CRC
	task automatic build_frame(input logic [7:0] ver, input logic [7:0] typ,
			input logic [31:0] len_field, input int body_len, input bit bad_crc);
		logic [31:0] crc;
		frame_buf.delete();
		for (int i = 0; i < 4; i++)
			frame_buf.insert(frame_buf.size(), cfg_magic[8 * i +: 8]);
		frame_buf.insert(frame_buf.size(), ver);
		frame_buf.insert(frame_buf.size(), typ);
		for (int i = 0; i < 4; i++)
			frame_buf.insert(frame_buf.size(), len_field[8 * i +: 8]);
		for (int i = 0; i < 4 + body_len; i++)
			frame_buf.insert(frame_buf.size(), 8'($urandom));
		crc = 32'hFFFFFFFF;
		foreach (frame_buf[i])
			crc = crc32_update(crc, frame_buf[i]);
		crc = ~crc;
		if (bad_crc)
			crc = crc ^ (32'd1 << $urandom_range(0, 31));
		for (int i = 0; i < 4; i++)
			frame_buf.insert(frame_buf.size(), crc[8 * i +: 8]);
	endtask

	// drop valid, let every expected transaction drain, then allow the pipeline to settle
	task automatic wait_idle();
		@(negedge clk) s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MAGIC_WORD: cfg_magic = val;
			REG_EXPECTED_VERSION: cfg_ver = val[7:0];
			REG_TYPE_MIN: cfg_tmin = val[7:0];
			REG_TYPE_MAX: cfg_tmax = val[7:0];
			REG_MAX_PAYLOAD: cfg_max = val[23:0];
			default: ;
		endcase
	endtask

	task automatic test_reset_config();
		tx_max_gap = 0;
		rx_mode = RX_ALWAYS;
		// empty payload with all-zero magic and the lowest type
		build_frame(8'd1, 8'd0, 32'd0, 0, 1'b0);
		send_prefix(frame_buf.size());
		build_frame(8'd1, 8'd255, 32'd65537, 0, 1'b0);
		send_prefix(10);
	endtask

	task automatic test_magic_search();
		wait_idle();
		write_reg(REG_MAGIC_WORD, 32'hFFFFFFFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h7F);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFE);
	endtask

	task automatic test_header_checks();
		wait_idle();
		// junk above the register width must be dropped
		write_reg(REG_EXPECTED_VERSION, 32'hA5A5A5FF);
		write_reg(REG_TYPE_MIN, 32'h10);
		write_reg(REG_TYPE_MAX, 32'h20);
		write_reg(REG_MAX_PAYLOAD, 32'h0);
		build_frame(8'hFE, 8'h10, 32'd0, 0, 1'b0);
		send_prefix(5);
		build_frame(8'hFF, 8'h0F, 32'd0, 0, 1'b0);
		send_prefix(6);
		build_frame(8'hFF, 8'h21, 32'd0, 0, 1'b0);
		send_prefix(6);
		build_frame(8'hFF, 8'h20, 32'd1, 0, 1'b0);
		send_prefix(10);
		build_frame(8'hFF, 8'h10, 32'h01000000, 0, 1'b0);
		send_prefix(10);
		wait_idle();
		// min above max: nothing passes
		write_reg(REG_TYPE_MIN, 32'h30);
		build_frame(8'hFF, 8'h20, 32'd0, 0, 1'b0);
		send_prefix(6);
	endtask

	task automatic test_payload_crc();
		wait_idle();
		write_reg(REG_MAGIC_WORD, 32'h3CC3A55A);
		write_reg(REG_EXPECTED_VERSION, 32'h0);
		write_reg(REG_TYPE_MIN, 32'h0);
		write_reg(REG_TYPE_MAX, 32'hFF);
		write_reg(REG_MAX_PAYLOAD, 32'hABFFFFFF);
		tx_max_gap = 3;
		tx_max_burst = 4;
		rx_mode = RX_RANDOM;
		build_frame(8'h00, 8'hFF, 32'd3, 3, 1'b0);
		send_prefix(frame_buf.size());
		build_frame(8'h00, 8'h00, 32'd2, 2, 1'b1);
		send_prefix(frame_buf.size());
		build_frame(8'h00, 8'h7E, 32'h80000000, 0, 1'b0);
		send_prefix(10);
	endtask

	task automatic test_backpressure();
		wait_idle();
		write_reg(REG_MAX_PAYLOAD, 32'd64);
		tx_max_gap = 0;
		tx_max_burst = 64;
		rx_mode = RX_ALWAYS;
		hold_req = 1'b1;
		build_frame(8'h00, 8'h42, 32'd48, 48, 1'b0);
		send_prefix(frame_buf.size());
	endtask

	// mostly good frames, with bad CRC, bad header fields, broken magic and noise mixed in
	task automatic run_random_phase(input int n_bytes);
		int unsigned start;
		int pick, cut, len, cap, k, lo, hi;
		logic [7:0] ver, typ, b;
		logic [31:0] lf;
		bit bad;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			pick = $urandom_range(0, 99);
			cap = (cfg_max < 24'd16) ? int'(cfg_max) : 16;
			len = (pick % 10 == 0 && cfg_max >= 24'd40) ? $urandom_range(17, 40)
				: $urandom_range(0, cap);
			lo = cfg_tmin;
			hi = cfg_tmax;
			typ = 8'($urandom_range(lo, hi));
			ver = cfg_ver;
			lf = 32'(len);
			bad = 1'b0;
			cut = 0;
			k = -1;
			if (pick < 62) begin
			end else if (pick < 70) begin
				bad = 1'b1;
			end else if (pick < 76) begin
				ver = cfg_ver ^ 8'($urandom_range(1, 255));
				cut = 5;
			end else if (pick < 82) begin
				if (lo > 0 && (hi == 255 || $urandom_range(0, 1) == 0)) begin
					typ = 8'($urandom_range(0, lo - 1));
					cut = 6;
				end else if (hi < 255) begin
					typ = 8'($urandom_range(hi + 1, 255));
					cut = 6;
				end
			end else if (pick < 88) begin
				if (cfg_max < 24'hFFFFFF && $urandom_range(0, 1) == 1)
					lf = {8'd0, cfg_max} + 32'($urandom_range(1, 100));
				else
					lf = $urandom | (32'd1 << $urandom_range(24, 31));
				cut = 10;
			end else if (pick < 94) begin
				k = $urandom_range(0, 3);
				cut = k + 1;
			end else begin
				// noise never starts a magic match, so the parser stays in search
				repeat ($urandom_range(1, 6)) begin
					do b = 8'($urandom); while (b == cfg_magic[7:0]);
					send_byte(b);
				end
				continue;
			end
			build_frame(ver, typ, lf, len, bad);
			if (k >= 0)
				frame_buf[k] = frame_buf[k] ^ 8'($urandom_range(1, 255));
			send_prefix((cut == 0) ? frame_buf.size() : cut);
		end
	endtask

	task automatic configure_random_phase(input logic [31:0] ver, input logic [31:0] tmin,
			input logic [31:0] tmax, input logic [31:0] maxp);
		wait_idle();
		write_reg(REG_MAGIC_WORD, $urandom);
		write_reg(REG_EXPECTED_VERSION, ver);
		write_reg(REG_TYPE_MIN, tmin);
		write_reg(REG_TYPE_MAX, tmax);
		write_reg(REG_MAX_PAYLOAD, maxp);
	endtask

	task automatic test_random();
		int a;
		a = $urandom_range(0, 255);
		configure_random_phase($urandom, 32'(a), 32'($urandom_range(a, 255)), 32'd32);
		tx_max_gap = 4;
		tx_max_burst = 6;
		rx_mode = RX_RANDOM;
		run_random_phase(250);

		configure_random_phase(32'h0, 32'h0, 32'h0, 32'hFFFFFF);
		tx_max_gap = 0;
		rx_mode = RX_ALWAYS;
		run_random_phase(250);

		configure_random_phase(32'hFF, 32'hFF, 32'hFF, 32'd8);
		tx_max_gap = 2;
		tx_max_burst = 12;
		rx_mode = RX_PERIODIC;
		run_random_phase(250);

		a = $urandom_range(0, 255);
		configure_random_phase($urandom, 32'(a), 32'($urandom_range(a, 255)),
			32'($urandom_range(0, 64)));
		tx_max_gap = 2;
		tx_max_burst = 5;
		rx_mode = RX_RANDOM;
		run_random_phase(250);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		test_reset_config();
		test_magic_search();
		test_header_checks();
		test_payload_crc();
		test_backpressure();
		test_random();
		wait_idle();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("[crc_checked_frame_decoder] OK");
		else
			$display("[crc_checked_frame_decoder] ERROR");
		$finish;
	end

endmodule
